### rtl/mpfb_pkg.sv
package mpfb_pkg;

  // store geometry
  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 64;
  localparam int STORE_PAGES = (MAX_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = MAX_WIDTH * STORE_PAGES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  // fixed widths of fields and derived values
  localparam int EW_W    = 9;          // effective width, up to 128
  localparam int EH_W    = 8;          // effective height, up to 64
  localparam int HB_W    = EH_W - 3;   // complete pages
  localparam int BIDX_W  = 10;
  localparam int CMP_W   = BIDX_W + 1;
  localparam int DCNT_W  = $clog2(BIDX_W + 1);
  localparam int CFG_IDX_W = 1;

  localparam logic [7:0] WIDTH_RESET  = 8'd128;
  localparam logic [6:0] HEIGHT_RESET = 7'd64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_GET  = 2'd1,
    OP_FILL = 2'd2,
    OP_BYTE = 2'd3
  } op_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic rd_px;
    logic wr_px;
    logic fill_init;
    logic rd_fill;
    logic wr_fill;
    logic fill_adv;
    logic div_start;
    logic div_step;
    logic rd_byte;
    logic res_clear;
    logic pix_done;
    logic fill_done;
    logic byte_done;
    logic out_load;
  } mpfb_cmd_t;

  typedef struct packed {
    op_t  op;
    logic clr_last;
    logic pix_ok;
    logic fill_ok;
    logic hb_zero;
    logic div_last;
    logic col_ok;
    logic fill_last_pg;
    logic fill_last_col;
    logic out_free;
  } mpfb_status_t;

endpackage

### rtl/mpfb_dpath.sv
module mpfb_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mpfb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                          cfg_wdata,
  input  logic [1:0]                          in_opcode,
  input  logic [7:0]                          in_x_start,
  input  logic [7:0]                          in_y_start,
  input  logic [7:0]                          in_x_end,
  input  logic [7:0]                          in_y_end,
  input  logic                                in_value,
  input  logic [9:0]                          in_byte_index,
  input  logic                                out_stall,
  input  mpfb_pkg::mpfb_cmd_t                 cmd,
  output mpfb_pkg::mpfb_status_t              status,
  output logic                                out_valid,
  output logic                                out_ok,
  output logic                                out_pixel,
  output logic [7:0]                          out_packed_byte
);
  import mpfb_pkg::*;

  logic [7:0]        width_r;
  logic [6:0]        height_r;
  op_t               op_r;
  logic [7:0]        x_r, y_r, xend_r, yend_r;
  logic              val_r;
  logic [BIDX_W-1:0] bidx_r;

  logic [ADDR_W-1:0] clr_cnt_r;
  logic [7:0]        fx_r;
  logic [4:0]        fpg_r;
  logic [BIDX_W-1:0] div_q_r;
  logic [HB_W-1:0]   div_rem_r;
  logic [DCNT_W-1:0] div_cnt_r;

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rd_data_r;

  logic       res_ok_r, res_px_r;
  logic [7:0] res_pb_r;
  logic       out_valid_r, out_ok_r, out_px_r;
  logic [7:0] out_pb_r;

  logic [EW_W-1:0]   eff_w;
  logic [EH_W-1:0]   eff_h;
  logic [HB_W-1:0]   hb;
  logic [7:0]        xe, ye, ye_m1;
  logic [ADDR_W-1:0] pix_addr, fill_addr, byte_addr, rd_addr, wr_addr;
  logic              mem_we, mem_re;
  logic [7:0]        wr_data, px_mask, px_new, fill_mask, fill_new;
  logic [HB_W:0]     div_trial;
  logic              div_bit;

  // visible window
  assign eff_w = (EW_W'(width_r) > EW_W'(MAX_WIDTH)) ? EW_W'(MAX_WIDTH) : EW_W'(width_r);
  assign eff_h = (EH_W'(height_r) > EH_W'(MAX_HEIGHT)) ? EH_W'(MAX_HEIGHT)
                                                       : EH_W'(height_r);
  assign hb    = eff_h[EH_W-1:3];

  // clipped rectangle bounds
  assign xe    = (EW_W'(xend_r) < eff_w) ? xend_r : eff_w[7:0];
  assign ye    = (yend_r < eff_h) ? yend_r : eff_h;
  assign ye_m1 = ye - 8'd1;

  assign pix_addr  = ADDR_W'(32'(x_r) * 32'(STORE_PAGES) + 32'(y_r[7:3]));
  assign fill_addr = ADDR_W'(32'(fx_r) * 32'(STORE_PAGES) + 32'(fpg_r));
  assign byte_addr = ADDR_W'(32'(div_q_r) * 32'(STORE_PAGES) + 32'(div_rem_r));

  assign px_mask = 8'd1 << y_r[2:0];
  assign px_new  = val_r ? (rd_data_r | px_mask) : (rd_data_r & ~px_mask);

  always_comb begin
    logic [7:0] row;
    fill_mask = '0;
    for (int b = 0; b < 8; b++) begin
      row          = {fpg_r, 3'(b)};
      fill_mask[b] = (row >= y_r) && (row < ye);
    end
  end
  assign fill_new = val_r ? (rd_data_r | fill_mask) : (rd_data_r & ~fill_mask);

  // restoring divide step, one quotient bit a cycle
  assign div_trial = {div_rem_r, div_q_r[BIDX_W-1]};
  assign div_bit   = div_trial >= {1'b0, hb};

  always_comb begin
    rd_addr = pix_addr;
    if (cmd.rd_fill) begin
      rd_addr = fill_addr;
    end else if (cmd.rd_byte) begin
      rd_addr = byte_addr;
    end
  end
  assign mem_re = cmd.rd_px | cmd.rd_fill | cmd.rd_byte;

  always_comb begin
    wr_addr = clr_cnt_r;
    wr_data = '0;
    if (cmd.wr_px) begin
      wr_addr = pix_addr;
      wr_data = px_new;
    end else if (cmd.wr_fill) begin
      wr_addr = fill_addr;
      wr_data = fill_new;
    end
  end
  assign mem_we = cmd.clr_step | cmd.wr_px | cmd.wr_fill;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_RESET;
      height_r    <= HEIGHT_RESET;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_WIDTH) begin
        width_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_HEIGHT) begin
        height_r <= cfg_wdata[6:0];
      end
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_opcode);
      x_r    <= in_x_start;
      y_r    <= in_y_start;
      xend_r <= in_x_end;
      yend_r <= in_y_end;
      val_r  <= in_value;
      bidx_r <= in_byte_index;
    end
    if (cmd.fill_init) begin
      fx_r  <= x_r;
      fpg_r <= y_r[7:3];
    end else if (cmd.fill_adv) begin
      if (status.fill_last_pg) begin
        fx_r  <= fx_r + 8'd1;
        fpg_r <= y_r[7:3];
      end else begin
        fpg_r <= fpg_r + 5'd1;
      end
    end
    if (cmd.div_start) begin
      div_q_r   <= bidx_r;
      div_rem_r <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_q_r   <= {div_q_r[BIDX_W-2:0], div_bit};
      div_rem_r <= div_bit ? HB_W'(div_trial - {1'b0, hb}) : div_trial[HB_W-1:0];
      div_cnt_r <= div_cnt_r + DCNT_W'(1);
    end
    if (cmd.res_clear) begin
      res_ok_r <= 1'b0;
      res_px_r <= 1'b0;
      res_pb_r <= '0;
    end else if (cmd.pix_done) begin
      res_ok_r <= 1'b1;
      res_px_r <= (op_r == OP_GET) ? rd_data_r[y_r[2:0]] : 1'b0;
      res_pb_r <= '0;
    end else if (cmd.fill_done) begin
      res_ok_r <= 1'b1;
      res_px_r <= 1'b0;
      res_pb_r <= '0;
    end else if (cmd.byte_done) begin
      res_ok_r <= 1'b1;
      res_px_r <= 1'b0;
      res_pb_r <= rd_data_r;
    end
    if (cmd.out_load) begin
      out_ok_r <= res_ok_r;
      out_px_r <= res_px_r;
      out_pb_r <= res_pb_r;
    end
  end

  assign status.op            = op_r;
  assign status.clr_last      = clr_cnt_r == ADDR_W'(STORE_BYTES - 1);
  assign status.pix_ok        = (EW_W'(x_r) < eff_w) && (y_r < eff_h);
  assign status.fill_ok       = (x_r < xe) && (y_r < ye);
  assign status.hb_zero       = hb == '0;
  assign status.div_last      = div_cnt_r == DCNT_W'(BIDX_W - 1);
  assign status.col_ok        = CMP_W'(div_q_r) < CMP_W'(eff_w);
  assign status.fill_last_pg  = fpg_r == ye_m1[7:3];
  assign status.fill_last_col = fx_r == xe - 8'd1;
  assign status.out_free      = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_pixel       = out_px_r;
  assign out_packed_byte = out_pb_r;

  a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !mem_re) else $error("store read and write in one cycle");

  a_fill_mask: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_fill |-> fill_mask != 8'd0) else $error("fill visits a byte outside the rows");

  a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall)) else $error("result overwrites a waiting item");

endmodule

### rtl/mpfb_ctrl.sv
module mpfb_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  mpfb_pkg::mpfb_status_t status,
  output mpfb_pkg::mpfb_cmd_t    cmd,
  output logic                   in_stall
);
  import mpfb_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR    = 10'b00_0000_0001,
    S_IDLE     = 10'b00_0000_0010,
    S_DECODE   = 10'b00_0000_0100,
    S_PIX      = 10'b00_0000_1000,
    S_FILL_RD  = 10'b00_0001_0000,
    S_FILL_WR  = 10'b00_0010_0000,
    S_DIV      = 10'b00_0100_0000,
    S_BYTE_CHK = 10'b00_1000_0000,
    S_BYTE_RD  = 10'b01_0000_0000,
    S_RESP     = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.op)
          OP_SET, OP_GET: begin
            if (status.pix_ok) begin
              cmd.rd_px = 1'b1;
              state_nxt = S_PIX;
            end else begin
              cmd.res_clear = 1'b1;
              state_nxt     = S_RESP;
            end
          end
          OP_FILL: begin
            if (status.fill_ok) begin
              cmd.fill_init = 1'b1;
              state_nxt     = S_FILL_RD;
            end else begin
              cmd.res_clear = 1'b1;
              state_nxt     = S_RESP;
            end
          end
          OP_BYTE: begin
            if (status.hb_zero) begin
              cmd.res_clear = 1'b1;
              state_nxt     = S_RESP;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          default: begin
            cmd.res_clear = 1'b1;
            state_nxt     = S_RESP;
          end
        endcase
      end
      S_PIX: begin
        cmd.wr_px    = status.op == OP_SET;
        cmd.pix_done = 1'b1;
        state_nxt    = S_RESP;
      end
      S_FILL_RD: begin
        cmd.rd_fill = 1'b1;
        state_nxt   = S_FILL_WR;
      end
      S_FILL_WR: begin
        cmd.wr_fill = 1'b1;
        if (status.fill_last_pg && status.fill_last_col) begin
          cmd.fill_done = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          cmd.fill_adv = 1'b1;
          state_nxt    = S_FILL_RD;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_BYTE_CHK;
        end
      end
      S_BYTE_CHK: begin
        if (status.col_ok) begin
          cmd.rd_byte = 1'b1;
          state_nxt   = S_BYTE_RD;
        end else begin
          cmd.res_clear = 1'b1;
          state_nxt     = S_RESP;
        end
      end
      S_BYTE_RD: begin
        cmd.byte_done = 1'b1;
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign in_stall = state_r != S_IDLE;

  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> in_stall) else $error("item accepted while busy");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> !in_stall) else $error("no return to idle after result");

endmodule

### rtl/mono_page_framebuffer.sv
// channel   direction  handshake           payload
// in_       input      in_valid/in_stall   opcode, x_start, y_start, x_end, y_end,
//                                          value, byte_index
// out_      output     out_valid/out_stall ok, pixel, packed_byte
// cfg_      input      cfg_we              cfg_index, cfg_wdata
//
// one item at a time, steps from accept to next accept:
//   set/get pixel: decode, store read, write for set, result (no read when
//   out of bounds); read byte: bit-serial divider for column and page, column
//   check, store read, result; fill: one read and one write on the store per column and page
// reset: a clearing pass zeroes all 1024 bytes of the store, input stalled meanwhile
// a waiting result sits in the output register; a stalled output holds the
// block only when the next result is ready to leave
module mono_page_framebuffer (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_opcode,
  input  logic [7:0]                     in_x_start,
  input  logic [7:0]                     in_y_start,
  input  logic [7:0]                     in_x_end,
  input  logic [7:0]                     in_y_end,
  input  logic                           in_value,
  input  logic [9:0]                     in_byte_index,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_ok,
  output logic                           out_pixel,
  output logic [7:0]                     out_packed_byte,
  // configuration writes, taken at any time
  input  logic                           cfg_we,
  input  logic [mpfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_wdata
);
  import mpfb_pkg::*;

  // command and status between sequencer and datapath
  mpfb_cmd_t    cmd;
  mpfb_status_t status;

  // sequencer: clearing pass, decode, pixel access, fill walk, divide, result
  mpfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // datapath: window registers, store, fill counters, divider, output register
  mpfb_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_opcode       (in_opcode),
    .in_x_start      (in_x_start),
    .in_y_start      (in_y_start),
    .in_x_end        (in_x_end),
    .in_y_end        (in_y_end),
    .in_value        (in_value),
    .in_byte_index   (in_byte_index),
    .out_stall       (out_stall),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_ok          (out_ok),
    .out_pixel       (out_pixel),
    .out_packed_byte (out_packed_byte)
  );

endmodule

### tb/mono_page_framebuffer_tb.sv
`timescale 1ns / 1ps

module mono_page_framebuffer_tb;
  import mpfb_pkg::*;

  // cycles without any item moving before the run is called hung
  // (covers the clearing pass plus a full-screen fill, with slack)
  localparam int STALL_LIMIT = 20000;

  // one framebuffer command as it goes on the input channel
  typedef struct {
    op_t        op;
    logic [7:0] x0;
    logic [7:0] y0;
    logic [7:0] x1;
    logic [7:0] y1;
    logic       val;
    logic [9:0] bidx;
  } fb_cmd_t;

  // one result item
  typedef struct {
    logic       ok;
    logic       pixel;
    logic [7:0] pbyte;
  } fb_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_opcode = '0;
  logic [7:0] in_x_start = '0;
  logic [7:0] in_y_start = '0;
  logic [7:0] in_x_end = '0;
  logic [7:0] in_y_end = '0;
  logic       in_value = 1'b0;
  logic [9:0] in_byte_index = '0;

  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_ok;
  logic       out_pixel;
  logic [7:0] out_packed_byte;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_wdata = '0;

  // commands waiting to go in, results predicted but not yet seen
  fb_cmd_t cmd_q[$];
  fb_res_t predicted_q[$];

  // shadow of the pixel store and the two window registers
  logic [7:0] shadow_store [0:STORE_BYTES-1];
  logic [7:0] width_reg = WIDTH_RESET;
  logic [6:0] height_reg = HEIGHT_RESET;

  // random idling on each side, switched off for a long stretch
  bit idle_on = 1'b1;
  bit stall_on = 1'b1;

  int errors = 0;
  int quiet_cycles = 0;
  fb_res_t want;

  always #4 clk = ~clk;

  mono_page_framebuffer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_x_start      (in_x_start),
    .in_y_start      (in_y_start),
    .in_x_end        (in_x_end),
    .in_y_end        (in_y_end),
    .in_value        (in_value),
    .in_byte_index   (in_byte_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_pixel       (out_pixel),
    .out_packed_byte (out_packed_byte),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // visible window, registers above the store size act as the store size
  function automatic int vis_width();
    return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
  endfunction

  function automatic int vis_height();
    return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
  endfunction

  // applies one command to the shadow store and returns its result
  function automatic fb_res_t apply_command(fb_cmd_t c);
    fb_res_t r;
    int ew;
    int eh;
    int xe;
    int ye;
    int pages;
    int col;
    int pg;
    ew = vis_width();
    eh = vis_height();
    r = '{ok: 1'b0, pixel: 1'b0, pbyte: 8'h00};
    case (c.op)
      OP_SET: begin
        if (c.x0 < ew && c.y0 < eh) begin
          shadow_store[c.x0 * STORE_PAGES + c.y0 / 8][c.y0 % 8] = c.val;
          r.ok = 1'b1;
        end
      end
      OP_GET: begin
        if (c.x0 < ew && c.y0 < eh) begin
          r.pixel = shadow_store[c.x0 * STORE_PAGES + c.y0 / 8][c.y0 % 8];
          r.ok = 1'b1;
        end
      end
      OP_FILL: begin
        // half-open rectangle clipped to the window
        xe = (c.x1 < ew) ? int'(c.x1) : ew;
        ye = (c.y1 < eh) ? int'(c.y1) : eh;
        for (int x = c.x0; x < xe; x++) begin
          for (int y = c.y0; y < ye; y++) begin
            shadow_store[x * STORE_PAGES + y / 8][y % 8] = c.val;
            r.ok = 1'b1;
          end
        end
      end
      default: begin
        // only complete pages count for packed reads
        pages = eh / 8;
        if (pages != 0) begin
          col = c.bidx / pages;
          pg  = c.bidx % pages;
          if (col < ew) begin
            r.pbyte = shadow_store[col * STORE_PAGES + pg];
            r.ok = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic push_cmd(op_t op, int x0, int y0, int x1, int y1, bit val, int bidx);
    fb_cmd_t c;
    c = '{op: op, x0: x0[7:0], y0: y0[7:0], x1: x1[7:0], y1: y1[7:0],
          val: val, bidx: bidx[9:0]};
    cmd_q.push_back(c);
  endtask

  // mostly inside the window or just past its edge, now and then anywhere in the field
  function automatic int pick_coord(int lim);
    if ($urandom_range(9, 0) == 0) return $urandom_range(255, 0);
    return $urandom_range(lim + 3, 0);
  endfunction

  // end of a fill span: mostly a short one, some empty or reversed, a few wild
  function automatic int pick_end(int start, int span);
    int sel;
    sel = $urandom_range(19, 0);
    if (sel == 0) return $urandom_range(255, 0);
    if (sel <= 2) return (start > 3) ? start - $urandom_range(3, 0) : 0;
    return (start + span > 255) ? 255 : start + $urandom_range(span, 1);
  endfunction

  task automatic push_random();
    fb_cmd_t c;
    int ew;
    int eh;
    int sel;
    int top;
    ew = vis_width();
    eh = vis_height();
    sel = $urandom_range(99, 0);
    // every field random on every op so each bit toggles
    c.x0   = 8'(pick_coord(ew));
    c.y0   = 8'(pick_coord(eh));
    c.x1   = 8'($urandom_range(255, 0));
    c.y1   = 8'($urandom_range(255, 0));
    c.val  = 1'($urandom_range(1, 0));
    c.bidx = 10'($urandom_range(1023, 0));
    if (sel < 35) begin
      c.op = OP_SET;
    end else if (sel < 60) begin
      c.op = OP_GET;
    end else if (sel < 75) begin
      c.op = OP_FILL;
      c.x1 = 8'(pick_end(int'(c.x0), 12));
      c.y1 = 8'(pick_end(int'(c.y0), 20));
    end else begin
      c.op = OP_BYTE;
      if ($urandom_range(9, 0) >= 3) begin
        top = ew * (eh / 8) + 3;
        c.bidx = 10'($urandom_range((top > 1023) ? 1023 : top, 0));
      end
    end
    cmd_q.push_back(c);
  endtask

  // waits until every command went in and every result came back
  task automatic drain_all();
    while (cmd_q.size() != 0 || predicted_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_WIDTH) width_reg = data;
    else height_reg = data[6:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // new window once the block is idle, then a batch of random commands
  task automatic run_phase(logic [7:0] w, logic [7:0] h, int n, bit idle, bit stall);
    drain_all();
    repeat (6) @(posedge clk);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    idle_on  = idle;
    stall_on = stall;
    repeat (n) push_random();
  endtask

  // driver: present the head of the command queue, hold it while stalled
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) predicted_q.push_back(apply_command(cmd_q.pop_front()));
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (cmd_q.size() != 0 && !(idle_on && $urandom_range(99, 0) < 16)) begin
        in_valid      <= 1'b1;
        in_opcode     <= cmd_q[0].op;
        in_x_start    <= cmd_q[0].x0;
        in_y_start    <= cmd_q[0].y0;
        in_x_end      <= cmd_q[0].x1;
        in_y_end      <= cmd_q[0].y1;
        in_value      <= cmd_q[0].val;
        in_byte_index <= cmd_q[0].bidx;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: random back-pressure, compare each result with the oldest prediction
  always @(posedge clk) begin
    out_stall <= rst_n && stall_on && ($urandom_range(99, 0) < 16);
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_q.size() == 0) begin
        $error("result item with nothing predicted: ok %0d pixel %0d packed_byte %02h",
               out_ok, out_pixel, out_packed_byte);
        errors++;
      end else begin
        want = predicted_q.pop_front();
        if (out_ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_ok);
          errors++;
        end
        if (out_pixel !== want.pixel) begin
          $error("pixel: expected %0d, got %0d", want.pixel, out_pixel);
          errors++;
        end
        if (out_packed_byte !== want.pbyte) begin
          $error("packed_byte: expected %02h, got %02h", want.pbyte, out_packed_byte);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles where no item moves on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    // store starts all zero, window at its reset size
    for (int i = 0; i < STORE_BYTES; i++) shadow_store[i] = 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: corners, out of bounds pixels, every fill corner case
    push_cmd(OP_GET, 0, 0, 0, 0, 1'b0, 0);         // cleared after reset
    push_cmd(OP_SET, 0, 0, 0, 0, 1'b1, 0);
    push_cmd(OP_SET, 127, 63, 0, 0, 1'b1, 0);
    push_cmd(OP_SET, 128, 0, 0, 0, 1'b1, 0);       // x just past the window
    push_cmd(OP_SET, 0, 64, 0, 0, 1'b1, 0);        // y just past the window
    push_cmd(OP_SET, 255, 255, 255, 255, 1'b1, 1023);
    push_cmd(OP_GET, 127, 63, 0, 0, 1'b0, 0);
    push_cmd(OP_GET, 0, 0, 0, 0, 1'b0, 0);
    push_cmd(OP_GET, 255, 0, 0, 0, 1'b0, 0);
    push_cmd(OP_BYTE, 0, 0, 0, 0, 1'b0, 0);        // top pixel in bit 0
    push_cmd(OP_BYTE, 0, 0, 0, 0, 1'b0, 1023);     // last byte, bottom pixel in bit 7
    push_cmd(OP_FILL, 10, 10, 20, 30, 1'b1, 0);
    push_cmd(OP_GET, 15, 20, 0, 0, 1'b0, 0);
    push_cmd(OP_BYTE, 0, 0, 0, 0, 1'b0, 81);       // partly covered page
    push_cmd(OP_FILL, 5, 5, 5, 9, 1'b1, 0);        // empty span
    push_cmd(OP_FILL, 20, 20, 10, 30, 1'b1, 0);    // reversed span
    push_cmd(OP_FILL, 200, 0, 255, 10, 1'b1, 0);   // wholly outside the window
    push_cmd(OP_FILL, 120, 60, 255, 255, 1'b1, 0); // clipped at the corner
    push_cmd(OP_BYTE, 0, 0, 0, 0, 1'b0, 1023);
    push_cmd(OP_FILL, 12, 12, 18, 26, 1'b0, 0);    // clear inside a filled area
    push_cmd(OP_GET, 15, 20, 0, 0, 1'b0, 0);
    push_cmd(OP_FILL, 0, 0, 255, 255, 1'b1, 0);    // whole screen
    push_cmd(OP_BYTE, 0, 0, 0, 0, 1'b0, 500);
    push_cmd(OP_FILL, 0, 0, 255, 255, 1'b0, 0);
    push_cmd(OP_BYTE, 0, 0, 0, 0, 1'b0, 1023);

    // random phases over several windows; each start waits for the block to go idle
    run_phase(8'd128, 8'd64, 260, 1'b1, 1'b1);
    run_phase(8'd1, 8'd8, 80, 1'b1, 1'b1);         // smallest legal window
    run_phase(8'd255, 8'hFF, 220, 1'b0, 1'b0);     // oversized registers, no idling
    run_phase(8'd0, 8'd64, 40, 1'b1, 1'b1);        // zero width, nothing in bounds
    run_phase(8'd77, 8'd13, 150, 1'b1, 1'b1);      // height with a partial page
    run_phase(8'd40, 8'd5, 80, 1'b1, 1'b1);        // no complete page at all
    run_phase(8'd128, 8'd0, 40, 1'b1, 1'b1);       // zero height
    run_phase(8'd100, 8'd48, 180, 1'b1, 1'b1);

    drain_all();
    repeat (40) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
